FILE: hw/rtl/glzw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared constants, command codes and result type for the decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

	localparam int DictEntries = 4096;
	localparam int MaxCodeBits = 12;
	localparam int AddrW       = 12;
	localparam int CountW      = 13;

	typedef enum logic [1:0] {
		MODE_BYTE    = 2'd0,
		MODE_PULL    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	localparam logic [0:0] CFG_ROOT_SIZE  = 1'b0;
	localparam logic [0:0] CFG_LINE_WIDTH = 1'b1;

	typedef struct packed {
		logic [7:0] pixel;
		logic       pixel_valid;
		logic       end_of_line;
		logic       end_of_image;
		logic       need_byte;
		logic       byte_rejected;
		logic       bad_code;
	} result_t;

	// Minimum code size clamped to the supported range.
	function automatic logic [3:0] eff_root(input logic [3:0] r);
		logic [3:0] v;
		v = r;
		if (v < 4'd2) v = 4'd2;
		if (v > 4'd9) v = 4'd9;
		if (v > 4'(MaxCodeBits - 1)) v = 4'(MaxCodeBits - 1);
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gif_lzw_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GIF LZW decoder unit
// Unpacks GIF image data into colour indices, at most one pixel per pull beat.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries mode and stream_byte.
// Mode 0 delivers a raw image-data byte (sub-block length bytes included),
// mode 1 pulls one pixel, mode 2 restarts the decoder for a new image.
// Every input beat yields exactly one result beat on the output channel
// (out_valid/out_ready) with the pixel and its status marks.
// Sequencing: byte, restart and no-op beats go through ST_EXEC and ST_DONE,
// and the next beat is accepted once the block is back in ST_IDLE.
// A pull that pops the pixel stack does one stack read (ST_POP, ST_FIN_POP).
// A pull that decodes a code walks the prefix chain through the table RAMs,
// ST_WALK and ST_WRD per chain entry, then ST_FIN, ST_EMIT and the pop;
// the following pulls of that string are served from the stack.
// The block works on one beat at a time; in_ready is low while a beat is
// in flight. A finished result waits in a holding register in front of the
// output register: while the receiver stalls, the block already accepts the
// next beat and works on it, and only waits before loading its next result.
// Reset (arst_n low) clears all control state and loads the register
// defaults (root_size 8, line_width 320). The dictionary and stack RAMs
// need no clearing; they are always written before they are read.
// Configuration writes are taken on any cycle and used live.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  stream_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       pixel,
	output logic             pixel_valid,
	output logic             end_of_line,
	output logic             end_of_image,
	output logic             need_byte,
	output logic             byte_rejected,
	output logic             bad_code
);
	localparam int AW = glzw_pkg::AddrW;
	localparam int CW = glzw_pkg::CountW;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b0_0000_0001,
		ST_EXEC    = 9'b0_0000_0010,
		ST_POP     = 9'b0_0000_0100,
		ST_WALK    = 9'b0_0000_1000,
		ST_WRD     = 9'b0_0001_0000,
		ST_FIN     = 9'b0_0010_0000,
		ST_EMIT    = 9'b0_0100_0000,
		ST_DONE    = 9'b0_1000_0000,
		ST_FIN_POP = 9'b1_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0]  root_size_q;
	logic [15:0] line_width_q;

	// Captured beat.
	logic [1:0] mode_q;
	logic [7:0] byte_q;

	// Decoder state.
	logic [23:0]   bit_buffer_q;
	logic [4:0]    bit_count_q;
	logic [7:0]    block_left_q;
	logic [3:0]    code_width_q;
	logic [CW-1:0] next_slot_q;
	logic [CW-1:0] slot_limit_q;
	logic [AW-1:0] old_code_q;
	logic [7:0]    first_char_q;
	logic          after_clear_q;
	logic          finished_q;
	logic [CW-1:0] stack_top_q;
	logic [15:0]   line_count_q;

	// Walk state.
	logic [AW-1:0] code_q;   // current chain code
	logic [AW-1:0] c_q;      // decoded code
	logic          rd_pend_q;

	// Result: res_n_q holds a finished result until the output register frees.
	glzw_pkg::result_t res_q, res_n_q;
	logic              res_valid_q;

	// RAM ports.
	logic          sfx_we, pfx_we, stk_we;
	logic [AW-1:0] tbl_addr, stk_addr;
	logic [7:0]    sfx_rdata, stk_rdata, stk_wdata;
	logic [AW-1:0] pfx_rdata;

	glzw_ram #(.Width(8), .Depth(glzw_pkg::DictEntries)) u_sfx (
		.clk(clk), .we(sfx_we), .addr(tbl_addr), .wdata(code_q[7:0]),
		.rdata(sfx_rdata));
	glzw_ram #(.Width(AW), .Depth(glzw_pkg::DictEntries)) u_pfx (
		.clk(clk), .we(pfx_we), .addr(tbl_addr), .wdata(old_code_q),
		.rdata(pfx_rdata));
	glzw_ram #(.Width(8), .Depth(glzw_pkg::DictEntries)) u_stk (
		.clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata),
		.rdata(stk_rdata));

	// Derived code values.
	logic [3:0]    root;
	logic [CW-1:0] clr_code, end_code, new_codes;
	logic [AW-1:0] cmask, c_dec;
	logic          stack_full;
	logic          push_first;

	always_comb begin
		root      = glzw_pkg::eff_root(root_size_q);
		clr_code  = CW'(1) << root;
		end_code  = clr_code + CW'(1);
		new_codes = clr_code + CW'(2);
		cmask     = AW'((CW'(1) << code_width_q) - CW'(1));
		c_dec     = bit_buffer_q[AW-1:0] & cmask;
		stack_full = (stack_top_q == CW'(glzw_pkg::DictEntries));
	end

	// A pull that decodes a code at or past the next free slot starts its
	// string with first_char, pushed while the sequencer is in ST_EXEC.
	assign push_first = (glzw_pkg::mode_t'(mode_q) == glzw_pkg::MODE_PULL)
		&& (stack_top_q == '0) && (bit_count_q >= 5'(code_width_q))
		&& (CW'(c_dec) != clr_code) && (CW'(c_dec) != end_code)
		&& !after_clear_q && (CW'(c_dec) >= next_slot_q);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = res_valid_q;
	assign pixel         = res_q.pixel;
	assign pixel_valid   = res_q.pixel_valid;
	assign end_of_line   = res_q.end_of_line;
	assign end_of_image  = res_q.end_of_image;
	assign need_byte     = res_q.need_byte;
	assign byte_rejected = res_q.byte_rejected;
	assign bad_code      = res_q.bad_code;

	// Line counter step for an emitted pixel.
	logic [15:0] cnt_next;
	assign cnt_next = line_count_q + 16'd1;

	// RAM control (combinational from state).
	always_comb begin
		sfx_we    = 1'b0;
		pfx_we    = 1'b0;
		stk_we    = 1'b0;
		tbl_addr  = code_q;
		stk_addr  = stack_top_q[AW-1:0];
		stk_wdata = sfx_rdata;
		case (state_q)
			ST_POP: begin
				stk_addr = AW'(stack_top_q - CW'(1));
			end
			ST_WRD: begin
				// Push the suffix read at code_q in ST_WALK.
				stk_we = ~stack_full;
			end
			ST_FIN: begin
				stk_wdata = code_q[7:0];
				stk_we    = ~stack_full;
			end
			ST_EMIT: begin
				tbl_addr = next_slot_q[AW-1:0];
				sfx_we   = rd_pend_q & (next_slot_q < CW'(glzw_pkg::DictEntries));
				pfx_we   = sfx_we;
				stk_addr = AW'(stack_top_q - CW'(1));
			end
			default: ;
		endcase
		if (state_q == ST_EXEC) begin
			// A code at or past the next slot pushes first_char.
			stk_wdata = first_char_q;
			stk_we    = push_first;
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin : seq_proc
		glzw_pkg::result_t res_d;
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			root_size_q   <= 4'd8;
			line_width_q  <= 16'd320;
			bit_buffer_q  <= '0;
			bit_count_q   <= '0;
			block_left_q  <= '0;
			code_width_q  <= 4'd9;
			next_slot_q   <= CW'(258);
			slot_limit_q  <= CW'(512);
			old_code_q    <= '0;
			first_char_q  <= '0;
			after_clear_q <= 1'b0;
			finished_q    <= 1'b0;
			stack_top_q   <= '0;
			line_count_q  <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
			res_n_q       <= '0;
			mode_q        <= '0;
			byte_q        <= '0;
			code_q        <= '0;
			c_q           <= '0;
			rd_pend_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == glzw_pkg::CFG_ROOT_SIZE) root_size_q <= cfg_data[3:0];
				else line_width_q <= cfg_data;
			end
			if (state_q == ST_DONE && (!res_valid_q || out_ready)) res_valid_q <= 1'b1;
			else if (out_valid && out_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						byte_q  <= stream_byte;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_d = '0;
					state_q <= ST_DONE;
					case (glzw_pkg::mode_t'(mode_q))
						glzw_pkg::MODE_RESTART: begin
							bit_buffer_q  <= '0;
							bit_count_q   <= '0;
							block_left_q  <= '0;
							code_width_q  <= root + 4'd1;
							next_slot_q   <= new_codes;
							slot_limit_q  <= CW'(1) << (root + 4'd1);
							old_code_q    <= '0;
							first_char_q  <= '0;
							after_clear_q <= 1'b0;
							finished_q    <= 1'b0;
							stack_top_q   <= '0;
							line_count_q  <= '0;
						end
						glzw_pkg::MODE_BYTE: begin
							if (!finished_q) begin
								if (block_left_q == 8'd0) begin
									if (byte_q == 8'd0) finished_q <= 1'b1;
									else block_left_q <= byte_q;
								end else if (bit_count_q > 5'd16) begin
									res_d.byte_rejected = 1'b1;
								end else begin
									bit_buffer_q <= bit_buffer_q
										| (24'(byte_q) << bit_count_q);
									bit_count_q  <= bit_count_q + 5'd8;
									block_left_q <= block_left_q - 8'd1;
								end
							end
						end
						glzw_pkg::MODE_PULL: begin
							if (stack_top_q != '0) begin
								state_q <= ST_POP;
							end else if (bit_count_q < 5'(code_width_q)) begin
								if (finished_q) res_d.end_of_image = 1'b1;
								else res_d.need_byte = 1'b1;
							end else if (CW'(c_dec) == end_code) begin
								// The end code also discards the buffered bits.
								finished_q   <= 1'b1;
								bit_buffer_q <= '0;
								bit_count_q  <= '0;
								res_d.end_of_image = 1'b1;
							end else begin
								bit_buffer_q <= bit_buffer_q >> code_width_q;
								bit_count_q  <= bit_count_q - 5'(code_width_q);
								if (CW'(c_dec) == clr_code) begin
									code_width_q  <= root + 4'd1;
									next_slot_q   <= new_codes;
									slot_limit_q  <= CW'(1) << (root + 4'd1);
									after_clear_q <= 1'b1;
								end else if (after_clear_q) begin
									after_clear_q <= 1'b0;
									if (CW'(c_dec) > next_slot_q) res_d.bad_code = 1'b1;
									res_d.pixel_valid = 1'b1;
									if (CW'(c_dec) >= next_slot_q) begin
										old_code_q   <= '0;
										first_char_q <= '0;
										res_d.pixel  = '0;
									end else begin
										old_code_q   <= c_dec;
										first_char_q <= c_dec[7:0];
										res_d.pixel  = c_dec[7:0];
									end
									if (cnt_next == line_width_q) begin
										res_d.end_of_line = 1'b1;
										line_count_q <= '0;
									end else line_count_q <= cnt_next;
								end else begin
									c_q <= c_dec;
									if (CW'(c_dec) >= next_slot_q) begin
										if (CW'(c_dec) > next_slot_q) res_d.bad_code = 1'b1;
										code_q <= old_code_q;
										// Push first_char now (stack empty here).
										stack_top_q <= CW'(1);
									end else begin
										code_q <= c_dec;
									end
									state_q <= ST_WALK;
								end
							end
						end
						default: ;
					endcase
					res_n_q <= res_d;
				end
				ST_WALK: begin
					// Decide whether the chain continues; tables read at code_q.
					if (CW'(code_q) >= new_codes && !stack_full) state_q <= ST_WRD;
					else state_q <= ST_FIN;
				end
				ST_WRD: begin
					// Read data for code_q is valid now; push suffix, follow prefix.
					if (!stack_full) stack_top_q <= stack_top_q + CW'(1);
					code_q  <= pfx_rdata;
					state_q <= ST_WALK;
				end
				ST_FIN: begin
					if (!stack_full) stack_top_q <= stack_top_q + CW'(1);
					rd_pend_q <= (next_slot_q < slot_limit_q);
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (rd_pend_q) begin
						first_char_q <= code_q[7:0];
						next_slot_q  <= next_slot_q + CW'(1);
						old_code_q   <= c_q;
						if ((next_slot_q + CW'(1)) >= slot_limit_q
							&& code_width_q < 4'(glzw_pkg::MaxCodeBits)) begin
							slot_limit_q <= slot_limit_q << 1;
							code_width_q <= code_width_q + 4'd1;
						end
					end else if (next_slot_q >= slot_limit_q
						&& code_width_q < 4'(glzw_pkg::MaxCodeBits)) begin
						slot_limit_q <= slot_limit_q << 1;
						code_width_q <= code_width_q + 4'd1;
					end
					rd_pend_q <= 1'b0;
					// Stack is non-empty; pop via the read issued this cycle.
					state_q <= ST_POP;
				end
				ST_POP: begin
					// Stack read addressed at top-1 this cycle; data next.
					stack_top_q <= stack_top_q - CW'(1);
					state_q     <= ST_FIN_POP;
				end
				ST_FIN_POP: begin
					// Keeps the bad_code mark a decoding pull may have set.
					res_d = res_n_q;
					res_d.pixel       = stk_rdata;
					res_d.pixel_valid = 1'b1;
					if (cnt_next == line_width_q) begin
						res_d.end_of_line = 1'b1;
						line_count_q <= '0;
					end else line_count_q <= cnt_next;
					res_n_q <= res_d;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || out_ready) begin
						res_q   <= res_n_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	ast_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	ast_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	ast_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_top_q <= CW'(glzw_pkg::DictEntries)) else $error("stack overflow");
	ast_width_bound: assert property (@(posedge clk) disable iff (!arst_n)
		code_width_q <= 4'(glzw_pkg::MaxCodeBits)) else $error("code width too big");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/glzw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GIF LZW generic RAM
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module glzw_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: bench/gif_lzw_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder unit testbench
// Feeds encoded GIF image streams, pixel pulls, restarts and noise beats
// into the decoder. Every result beat is checked against a cycle-free
// model of the decoder kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit_tb;

	// The scoreboard keeps its own copy of the decoder state and predicts
	// one result per accepted input beat.
	class lzw_pixel_scoreboard;
		int unsigned root_reg, width_reg;
		int unsigned bit_buf, bit_cnt, blk_left, code_w, next_slot, slot_lim;
		int unsigned old_code, first_ch, after_clr, done, stack_top, line_cnt;
		logic [7:0]  suffix_mem [glzw_pkg::DictEntries];
		logic [11:0] prefix_mem [glzw_pkg::DictEntries];
		logic [7:0]  stack_mem  [glzw_pkg::DictEntries];
		glzw_pkg::result_t pending_pixels [$];
		int          errors;

		function new();
			root_reg  = 8;
			width_reg = 320;
			errors    = 0;
			restart();
		endfunction

		function int unsigned root_clamped();
			int unsigned r;
			r = root_reg;
			if (r < 2) r = 2;
			if (r > 9) r = 9;
			if (r > glzw_pkg::MaxCodeBits - 1) r = glzw_pkg::MaxCodeBits - 1;
			return r;
		endfunction

		function void restart();
			int unsigned r;
			r = root_clamped();
			bit_buf = 0; bit_cnt = 0; blk_left = 0;
			code_w = r + 1;
			next_slot = (1 << r) + 2;
			slot_lim = 1 << code_w;
			old_code = 0; first_ch = 0; after_clr = 0; done = 0;
			stack_top = 0; line_cnt = 0;
		endfunction

		function void set_reg(logic idx, int unsigned v);
			if (idx == glzw_pkg::CFG_ROOT_SIZE) root_reg = v & 4'hf;
			else width_reg = v & 16'hffff;
		endfunction

		// True when a pull would only report that it needs more bytes.
		function bit starved();
			return stack_top == 0 && bit_cnt < code_w;
		endfunction

		function void push_pixel(int unsigned v);
			if (stack_top < glzw_pkg::DictEntries) begin
				stack_mem[stack_top] = v[7:0];
				stack_top++;
			end
		endfunction

		function void emit(ref glzw_pkg::result_t res, input int unsigned v);
			int unsigned cnt;
			cnt = (line_cnt + 1) & 16'hffff;
			res.pixel = v[7:0];
			res.pixel_valid = 1'b1;
			if (cnt == width_reg) begin
				res.end_of_line = 1'b1;
				line_cnt = 0;
			end else begin
				line_cnt = cnt;
			end
		endfunction

		function glzw_pkg::result_t accept_beat(glzw_pkg::mode_t m, logic [7:0] b);
			glzw_pkg::result_t res;
			int unsigned r, clr, endc, newcodes, c, code;
			res = '0;
			case (m)
				glzw_pkg::MODE_RESTART: restart();
				glzw_pkg::MODE_BYTE: begin
					if (!done) begin
						if (blk_left == 0) begin
							if (b == 0) done = 1;
							else blk_left = b;
						end else if (bit_cnt > 16) begin
							res.byte_rejected = 1'b1;
						end else begin
							bit_buf = (bit_buf | (int'(b) << bit_cnt)) & 24'hffffff;
							bit_cnt += 8;
							blk_left--;
						end
					end
				end
				glzw_pkg::MODE_PULL: begin
					if (stack_top > 0) begin
						stack_top--;
						emit(res, stack_mem[stack_top]);
					end else if (bit_cnt < code_w) begin
						if (done) res.end_of_image = 1'b1;
						else res.need_byte = 1'b1;
					end else begin
						c = bit_buf & ((1 << code_w) - 1) & 12'hfff;
						bit_buf = bit_buf >> code_w;
						bit_cnt -= code_w;
						r = root_clamped();
						clr = 1 << r;
						endc = clr + 1;
						newcodes = clr + 2;
						if (c == clr) begin
							code_w = r + 1;
							next_slot = newcodes;
							slot_lim = 1 << code_w;
							after_clr = 1;
						end else if (c == endc) begin
							done = 1;
							bit_buf = 0;
							bit_cnt = 0;
							res.end_of_image = 1'b1;
						end else if (after_clr) begin
							after_clr = 0;
							if (c > next_slot) res.bad_code = 1'b1;
							if (c >= next_slot) c = 0;
							old_code = c;
							first_ch = c & 8'hff;
							emit(res, c);
						end else begin
							code = c;
							if (code >= next_slot) begin
								if (code > next_slot) res.bad_code = 1'b1;
								code = old_code;
								push_pixel(first_ch);
							end
							// Walk the prefix chain, pushing suffixes last to first.
							while (code >= newcodes && stack_top < glzw_pkg::DictEntries) begin
								if (code < glzw_pkg::DictEntries) begin
									push_pixel(suffix_mem[code]);
									code = prefix_mem[code];
								end else begin
									push_pixel(0);
									code = 0;
								end
							end
							push_pixel(code);
							if (next_slot < slot_lim) begin
								first_ch = code & 8'hff;
								if (next_slot < glzw_pkg::DictEntries) begin
									suffix_mem[next_slot] = first_ch[7:0];
									prefix_mem[next_slot] = old_code[11:0];
								end
								next_slot++;
								old_code = c;
							end
							if (next_slot >= slot_lim && code_w < glzw_pkg::MaxCodeBits) begin
								slot_lim = slot_lim << 1;
								code_w++;
							end
							if (stack_top > 0) begin
								stack_top--;
								emit(res, stack_mem[stack_top]);
							end
						end
					end
				end
				default: ;
			endcase
			pending_pixels.push_back(res);
			return res;
		endfunction

		function void compare_field(string name, int unsigned e, int unsigned a);
			if (e != a) begin
				$display("%0t: mismatch on %s, expected %0d, actual %0d", $realtime, name, e, a);
				errors++;
			end
		endfunction

		function void check_beat(glzw_pkg::result_t act);
			glzw_pkg::result_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $realtime, act);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			compare_field("pixel", e.pixel, act.pixel);
			compare_field("pixel_valid", e.pixel_valid, act.pixel_valid);
			compare_field("end_of_line", e.end_of_line, act.end_of_line);
			compare_field("end_of_image", e.end_of_image, act.end_of_image);
			compare_field("need_byte", e.need_byte, act.need_byte);
			compare_field("byte_rejected", e.byte_rejected, act.byte_rejected);
			compare_field("bad_code", e.bad_code, act.bad_code);
		endfunction
	endclass

	localparam int CycleLimit = 3000000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [15:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	glzw_pkg::mode_t   mode;
	logic [7:0]        stream_byte;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        pixel;
	logic              pixel_valid;
	logic              end_of_line;
	logic              end_of_image;
	logic              need_byte;
	logic              byte_rejected;
	logic              bad_code;
	glzw_pkg::result_t got;

	gif_lzw_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.stream_byte  (stream_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel        (pixel),
		.pixel_valid  (pixel_valid),
		.end_of_line  (end_of_line),
		.end_of_image (end_of_image),
		.need_byte    (need_byte),
		.byte_rejected(byte_rejected),
		.bad_code     (bad_code)
	);

	assign got = {pixel, pixel_valid, end_of_line, end_of_image, need_byte,
		byte_rejected, bad_code};

	lzw_pixel_scoreboard board = new();

	int  cycles;
	int  beats_sent;
	bit  calm;       // when set, neither side inserts gaps
	bit  hold_req;   // asks the receiver for one long stall

	// Encoder-side copy of the code width bookkeeping, used to pick legal
	// codes and to pack them at the width the decoder will read them with.
	int unsigned enc_root, enc_w, enc_next, enc_lim, enc_after_clr;
	int unsigned code_list [$];
	logic [7:0]  stream_q [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (calm || p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Receiver: checks every result beat and stalls at random. A hold
	// request keeps out_ready low for a long stretch so that the block
	// fills up and pushes back on its input.
	initial begin : receiver
		int stall;
		int long_hold;
		stall = 0;
		long_hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_beat(got);
			if (hold_req) begin
				hold_req = 1'b0;
				long_hold = 400;
			end
			if (long_hold > 0) begin
				long_hold--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = gap_len();
				out_ready <= (stall == 0);
			end
		end
	end

	function automatic void enc_restart();
		enc_w = enc_root + 1;
		enc_next = (1 << enc_root) + 2;
		enc_lim = 1 << enc_w;
		enc_after_clr = 0;
	endfunction

	// Mirrors the decoder's slot and width updates for one code.
	function automatic void enc_advance(int unsigned c);
		int unsigned clr;
		clr = 1 << enc_root;
		if (c == clr) begin
			enc_w = enc_root + 1;
			enc_next = clr + 2;
			enc_lim = 1 << enc_w;
			enc_after_clr = 1;
		end else if (enc_after_clr) begin
			enc_after_clr = 0;
		end else begin
			if (enc_next < enc_lim) enc_next++;
			if (enc_next >= enc_lim && enc_w < glzw_pkg::MaxCodeBits) begin
				enc_lim = enc_lim << 1;
				enc_w++;
			end
		end
	endfunction

	// Appends n random codes that only reference written table entries.
	// A code above the next slot is only used right after a clear, where
	// the decoder maps it to zero.
	function automatic void gen_codes(int n, int lit_pct);
		int unsigned clr, c, p;
		clr = 1 << enc_root;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (enc_after_clr && p < 10 && enc_next < (1 << enc_w) - 1)
				c = $urandom_range(enc_next + 1, (1 << enc_w) - 1);
			else if (!enc_after_clr && p < 4 && lit_pct < 90)
				c = clr;
			else if (enc_after_clr || p < lit_pct || enc_next <= clr + 2)
				c = $urandom_range(0, clr - 1);
			else if (p < 90 || enc_next >= enc_lim)
				c = $urandom_range(clr + 2, enc_next - 1);
			else
				c = enc_next;
			code_list.push_back(c);
			enc_advance(c);
		end
	endfunction

	// Packs the code list LSB first and cuts it into sub-blocks, closed by
	// a zero length byte.
	function automatic void pack_stream();
		int unsigned acc, nbits, len;
		logic [7:0] data [$];
		enc_restart();
		acc = 0;
		nbits = 0;
		foreach (code_list[i]) begin
			acc |= code_list[i] << nbits;
			nbits += enc_w;
			enc_advance(code_list[i]);
			while (nbits >= 8) begin
				data.push_back(acc[7:0]);
				acc >>= 8;
				nbits -= 8;
			end
		end
		if (nbits > 0) data.push_back(acc[7:0]);
		while (data.size() > 0) begin
			len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 8);
			if (len > data.size()) len = data.size();
			stream_q.push_back(len[7:0]);
			repeat (len) stream_q.push_back(data.pop_front());
		end
		stream_q.push_back(8'd0);
		code_list.delete();
	endfunction

	task automatic send_beat(glzw_pkg::mode_t m, logic [7:0] b,
		output glzw_pkg::result_t res);
		int g;
		in_valid <= 1'b1;
		mode <= m;
		stream_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = board.accept_beat(m, b);
		beats_sent++;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			mode <= glzw_pkg::mode_t'($urandom_range(0, 3));
			stream_byte <= 8'($urandom);
			repeat (g) @(posedge clk);
		end
	endtask

	// Withdraws the input and waits until every result has been checked.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending_pixels.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_config(logic [3:0] root, logic [15:0] lw);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= glzw_pkg::CFG_ROOT_SIZE;
		cfg_data <= {12'd0, root};
		@(posedge clk);
		board.set_reg(glzw_pkg::CFG_ROOT_SIZE, root);
		cfg_index <= glzw_pkg::CFG_LINE_WIDTH;
		cfg_data <= lw;
		@(posedge clk);
		board.set_reg(glzw_pkg::CFG_LINE_WIDTH, lw);
		cfg_we <= 1'b0;
		enc_root = board.root_clamped();
	endtask

	// Restarts the decoder, then streams bytes and pulls pixels until the
	// image ends. Bytes go in when the decoder starves and sometimes early,
	// which also provokes refused bytes; a refused byte is offered again.
	task automatic run_image();
		glzw_pkg::result_t res;
		send_beat(glzw_pkg::MODE_RESTART, 8'($urandom), res);
		calm = ($urandom_range(0, 3) == 0);
		forever begin
			if (stream_q.size() > 0 && (board.starved() || $urandom_range(0, 99) < 30)) begin
				send_beat(glzw_pkg::MODE_BYTE, stream_q[0], res);
				if (!res.byte_rejected) void'(stream_q.pop_front());
			end else begin
				send_beat(glzw_pkg::MODE_PULL, 8'($urandom), res);
				if (res.end_of_image) break;
			end
		end
		// Trailing noise: no-op beats, ignored bytes and extra pulls.
		repeat ($urandom_range(0, 3)) begin
			send_beat($urandom_range(0, 1) ? glzw_pkg::MODE_NOP : glzw_pkg::MODE_BYTE,
				8'($urandom), res);
			send_beat(glzw_pkg::MODE_PULL, 8'($urandom), res);
		end
		stream_q.delete();
		calm = 1'b0;
	endtask

	// Packs and runs an image from an explicit code list.
	task automatic directed_image(int unsigned codes [$]);
		code_list = codes;
		pack_stream();
		run_image();
	endtask

	initial begin : stimulus
		int unsigned lw_pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = glzw_pkg::CFG_ROOT_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = glzw_pkg::MODE_NOP;
		stream_byte = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		beats_sent = 0;
		enc_root = 8;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default setup: clear, top literal, literal 0, the code equal to the
		// next free slot, an existing string, then the end code.
		directed_image({256, 255, 0, 259, 258, 257});
		// Root below the range clamps to 2; one pixel per line; a code
		// past the next slot right after a clear.
		write_config(4'd0, 16'd1);
		directed_image({4, 7, 3, 6, 4, 0, 5});
		// Root above the range clamps to 9; line width 0 acts as 65536.
		write_config(4'd15, 16'd0);
		directed_image({512, 511, 514, 513});
		write_config(4'd9, 16'd65535);
		directed_image({0, 255, 511, 513});

		// A literal-heavy image at root 2 with no clears, so the code
		// width grows through several steps.
		write_config(4'd2, 16'd7);
		enc_restart();
		gen_codes(350, 90);
		code_list.push_back(1 << enc_root | 1);
		pack_stream();
		hold_req = 1'b1;
		run_image();

		// Random images under a changing setup.
		while (beats_sent < 1550) begin
			if ($urandom_range(0, 2) == 0) begin
				lw_pick = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 40);
				write_config(4'($urandom), lw_pick[15:0]);
			end
			enc_restart();
			if ($urandom_range(0, 1)) begin
				code_list.push_back(1 << enc_root);
				enc_advance(1 << enc_root);
			end
			gen_codes($urandom_range(5, 80), 40);
			// Most images close with the end code, some only with the
			// zero length sub-block.
			if ($urandom_range(0, 9) != 0) code_list.push_back((1 << enc_root) + 1);
			pack_stream();
			if ($urandom_range(0, 30) == 0) hold_req = 1'b1;
			run_image();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
